@@ design/wawe_pkg.sv @@
// Shared types, codes, easing curves and helpers of the window animation easing engine.
package wawe_pkg;

	localparam logic [2:0] FUNC_START     = 3'd0;
	localparam logic [2:0] FUNC_START_MIN = 3'd1;
	localparam logic [2:0] FUNC_TICK      = 3'd2;
	localparam logic [2:0] FUNC_CANCEL    = 3'd3;
	localparam logic [2:0] FUNC_APPLY     = 3'd4;

	localparam logic [2:0] KIND_OPEN    = 3'd0;
	localparam logic [2:0] KIND_CLOSE   = 3'd1;
	localparam logic [2:0] KIND_RESTORE = 3'd2;
	localparam logic [2:0] KIND_SHADE   = 3'd3;
	localparam logic [2:0] KIND_UNSHADE = 3'd4;
	localparam logic [2:0] KIND_MIN     = 3'd5;
	localparam logic [2:0] KIND_HOLD    = 3'd6;

	localparam logic [2:0] RES_STARTED   = 3'd0;
	localparam logic [2:0] RES_NO_SLOT   = 3'd1;
	localparam logic [2:0] RES_FINISHED  = 3'd2;
	localparam logic [2:0] RES_CANCELLED = 3'd3;
	localparam logic [2:0] RES_GEOMETRY  = 3'd4;
	localparam logic [2:0] RES_TICK_DONE = 3'd5;

	localparam logic [2:0] CFG_OPEN     = 3'd0;
	localparam logic [2:0] CFG_CLOSE    = 3'd1;
	localparam logic [2:0] CFG_RESTORE  = 3'd2;
	localparam logic [2:0] CFG_SHADE    = 3'd3;
	localparam logic [2:0] CFG_UNSHADE  = 3'd4;
	localparam logic [2:0] CFG_MINIMIZE = 3'd5;

	localparam logic [9:0] FRAMES_RESET = 10'd16;
	localparam logic [8:0] T_FULL = 9'd256;

	localparam logic [7:0] CURVE_OUT [64] = '{
		8'd0, 8'd4, 8'd8, 8'd12, 8'd16, 8'd20, 8'd24, 8'd28,
		8'd32, 8'd36, 8'd40, 8'd44, 8'd47, 8'd51, 8'd55, 8'd58,
		8'd62, 8'd65, 8'd68, 8'd72, 8'd75, 8'd78, 8'd81, 8'd84,
		8'd87, 8'd90, 8'd92, 8'd95, 8'd98, 8'd100, 8'd103, 8'd105,
		8'd107, 8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd120, 8'd122,
		8'd124, 8'd126, 8'd128, 8'd130, 8'd131, 8'd133, 8'd135, 8'd136,
		8'd138, 8'd139, 8'd141, 8'd142, 8'd143, 8'd145, 8'd146, 8'd147,
		8'd148, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd156};

	localparam logic [7:0] CURVE_BOUNCE [64] = '{
		8'd0, 8'd3, 8'd7, 8'd12, 8'd18, 8'd25, 8'd32, 8'd41,
		8'd50, 8'd60, 8'd71, 8'd83, 8'd96, 8'd109, 8'd121, 8'd132,
		8'd143, 8'd152, 8'd160, 8'd168, 8'd176, 8'd184, 8'd191, 8'd197,
		8'd203, 8'd209, 8'd215, 8'd220, 8'd224, 8'd228, 8'd232, 8'd236,
		8'd238, 8'd240, 8'd241, 8'd242, 8'd243, 8'd244, 8'd246, 8'd248,
		8'd250, 8'd252, 8'd253, 8'd254, 8'd254, 8'd253, 8'd252, 8'd251,
		8'd252, 8'd253, 8'd254, 8'd255, 8'd255, 8'd254, 8'd253, 8'd254,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};

	localparam logic [7:0] CURVE_IN [64] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1,
		8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd9, 8'd12,
		8'd14, 8'd17, 8'd21, 8'd25, 8'd29, 8'd34, 8'd39, 8'd45,
		8'd51, 8'd58, 8'd65, 8'd73, 8'd82, 8'd91, 8'd101, 8'd112,
		8'd123, 8'd135, 8'd147, 8'd160, 8'd173, 8'd186, 8'd200, 8'd213,
		8'd226, 8'd234, 8'd238, 8'd242, 8'd244, 8'd246, 8'd248, 8'd250,
		8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
	} rect_t;

	typedef struct packed {
		logic [15:0] window;
		logic [2:0]  kind;
		logic [9:0]  frame;
		logic [9:0]  dur;
		rect_t       src;
		rect_t       dst;
	} slot_t;

	typedef struct packed {
		logic [2:0]         func;
		logic [15:0]        window_id;
		logic [2:0]         anim_kind;
		logic signed [15:0] win_x;
		logic signed [15:0] win_y;
		logic [14:0]        win_w;
		logic [14:0]        win_h;
		logic [14:0]        saved_height;
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic [14:0]        target_w;
		logic [14:0]        target_h;
	} req_t;

	typedef struct packed {
		logic [2:0]         result_kind;
		logic [15:0]        event_window;
		logic [2:0]         finished_kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [14:0]        size_w;
		logic [14:0]        size_h;
		logic [7:0]         alpha;
		logic               any_active;
		logic               last_item;
	} rsp_t;

	typedef struct packed {
		logic       start;
		logic [9:0] frame;
		logic [9:0] dur;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [5:0] quot;
	} div_rsp_t;

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		logic signed [15:0] r;
		if (v > 17'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -17'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic [7:0] curve(input logic [2:0] kind, input logic [5:0] idx);
		logic [7:0] r;
		if (kind == KIND_MIN || kind == KIND_SHADE) begin
			r = CURVE_IN[idx];
		end else if (kind == KIND_UNSHADE) begin
			r = CURVE_BOUNCE[idx];
		end else begin
			r = CURVE_OUT[idx];
		end
		return r;
	endfunction

endpackage

@@ design/wawe_if.sv @@
// Handshake interfaces for requests, results and configuration writes.
interface wawe_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic [15:0]        window_id;
	logic [2:0]         anim_kind;
	logic signed [15:0] win_x;
	logic signed [15:0] win_y;
	logic [14:0]        win_w;
	logic [14:0]        win_h;
	logic [14:0]        saved_height;
	logic signed [15:0] target_x;
	logic signed [15:0] target_y;
	logic [14:0]        target_w;
	logic [14:0]        target_h;
	modport source(output valid, func, window_id, anim_kind, win_x, win_y, win_w, win_h,
		saved_height, target_x, target_y, target_w, target_h, input ready);
	modport sink(input valid, func, window_id, anim_kind, win_x, win_y, win_w, win_h,
		saved_height, target_x, target_y, target_w, target_h, output ready);
endinterface

interface wawe_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         result_kind;
	logic [15:0]        event_window;
	logic [2:0]         finished_kind;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [14:0]        size_w;
	logic [14:0]        size_h;
	logic [7:0]         alpha;
	logic               any_active;
	logic               last_item;
	modport source(output valid, result_kind, event_window, finished_kind, pos_x, pos_y,
		size_w, size_h, alpha, any_active, last_item, input ready);
	modport sink(input valid, result_kind, event_window, finished_kind, pos_x, pos_y,
		size_w, size_h, alpha, any_active, last_item, output ready);
endinterface

interface wawe_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [9:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ design/wawe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module wawe_ram #(
	parameter int Width = 8,
	parameter int Depth = 8,
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ design/wawe_div.sv @@
// Restoring divider that forms the easing table index frame*63/duration, one bit a cycle.
module wawe_div import wawe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [15:0] rem_q;
	logic [9:0]  den_q;
	logic [2:0]  step_q;
	logic [5:0]  quot_q;
	logic        busy_q;
	logic        done_q;
	logic [15:0] cand;

	assign cand = {6'd0, den_q} << step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == 3'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {req.frame, 6'd0} - {6'd0, req.frame};
			den_q  <= req.dur;
			step_q <= 3'd5;
			quot_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= cand) begin
				rem_q <= rem_q - cand;
				quot_q[step_q] <= 1'b1;
			end
			if (step_q != 3'd0) begin
				step_q <= step_q - 3'd1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule

@@ design/window_animation_easing_engine_core.sv @@
// Top level: slot table sequencer, interpolation datapath and result register.
// Each known request reads then evaluates the slots in turn before it emits; start and
// apply stop at a match, and a tick makes a second pass to report finished slots.
// Apply adds the six-step index divider and four lerps sharing one multiplier.
// One request is in flight at a time; results leave through a one-deep output register.
// Reset clears the active bits and the sequencer and sets every duration to 16 frames;
// slot memory contents are not cleared and are read only for active slots.
module window_animation_easing_engine_core import wawe_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	wawe_req_if.sink  req,
	wawe_rsp_if.source rsp,
	wawe_cfg_if.sink  cfg
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_READ  = 4'd1;
	localparam logic [3:0] ST_EVAL  = 4'd2;
	localparam logic [3:0] ST_START = 4'd3;
	localparam logic [3:0] ST_TAIL  = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_MUL   = 4'd6;
	localparam logic [3:0] ST_ACC   = 4'd7;
	localparam logic [3:0] ST_GEOM  = 4'd8;

	logic [3:0]       state_q, state_d;
	logic [IW-1:0]    idx_q, idx_d;
	logic [SLOTS-1:0] active_q, active_d;
	logic [SLOTS-1:0] done_q, done_d;
	logic             found_q, found_d;
	logic [IW-1:0]    sel_q, sel_d;
	logic             fin_q, fin_d;
	logic [1:0]       lane_q, lane_d;
	req_t             req_q;
	slot_t            slot_q;
	logic [8:0]       t_q;
	logic signed [27:0] prod_q;
	logic signed [17:0] lerp_q [4];
	logic [9:0]       open_q, close_q, restore_q, shade_q, unshade_q, minimize_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic             req_fire, out_free, emit;
	rsp_t             emit_item;
	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	slot_t            ram_wdata, rd, tick_slot, new_slot;
	logic [$bits(slot_t)-1:0] ram_rdata;
	logic             match, is_last;
	logic [9:0]       frame1;
	logic [IW-1:0]    free_idx;
	logic             free_any;
	logic [IW-1:0]    start_idx;
	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic signed [17:0] a_sel, b_sel, ow, oh, ox, oy;
	logic signed [27:0] qt;
	logic [7:0]       alpha_v;
	logic signed [16:0] xw4, yh4, xw2, yh2;

	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free = !out_valid_q || rsp.ready;

	assign rd = slot_t'(ram_rdata);
	assign match = active_q[idx_q] && rd.window == req_q.window_id;
	assign is_last = (idx_q == LAST);
	assign frame1 = rd.frame + 10'd1;

	wawe_ram #(.Width($bits(slot_t)), .Depth(SLOTS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(idx_q), .rdata(ram_rdata)
	);

	wawe_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign start_idx = found_q ? sel_q : free_idx;

	always_comb begin
		tick_slot = rd;
		tick_slot.frame = frame1;
	end

	assign xw4 = 17'(req_q.win_x) + 17'({2'd0, req_q.win_w[14:2]});
	assign yh4 = 17'(req_q.win_y) + 17'({2'd0, req_q.win_h[14:2]});
	assign xw2 = 17'(req_q.win_x) + 17'({1'b0, req_q.win_w[14:1]});
	assign yh2 = 17'(req_q.win_y) + 17'({1'b0, req_q.win_h[14:1]});

	always_comb begin
		new_slot.window = req_q.window_id;
		new_slot.kind = req_q.anim_kind;
		new_slot.frame = '0;
		new_slot.dur = open_q;
		new_slot.src = '{req_q.win_x, req_q.win_y, req_q.win_w, req_q.win_h};
		new_slot.dst = '{req_q.win_x, req_q.win_y, req_q.win_w, req_q.win_h};
		if (req_q.func == FUNC_START_MIN) begin
			new_slot.kind = KIND_MIN;
			new_slot.dur = minimize_q;
			new_slot.dst = '{req_q.target_x, req_q.target_y, req_q.target_w, req_q.target_h};
		end else begin
			case (req_q.anim_kind)
				KIND_OPEN: begin
					new_slot.src = '{sat16(xw4), sat16(yh4), {1'b0, req_q.win_w[14:1]},
						{1'b0, req_q.win_h[14:1]}};
				end
				KIND_CLOSE: begin
					new_slot.dur = close_q;
					new_slot.dst = '{sat16(xw4), sat16(yh4), {1'b0, req_q.win_w[14:1]},
						{1'b0, req_q.win_h[14:1]}};
				end
				KIND_RESTORE: begin
					new_slot.dur = restore_q;
					new_slot.src = '{sat16(xw2), sat16(yh2), 15'd0, 15'd0};
				end
				KIND_SHADE: begin
					new_slot.dur = shade_q;
					new_slot.dst.h = '0;
				end
				KIND_UNSHADE: begin
					new_slot.dur = unshade_q;
					new_slot.src.h = '0;
					new_slot.dst.h = (req_q.saved_height != '0) ? req_q.saved_height
						: req_q.win_h;
				end
				default: begin
					new_slot.kind = KIND_HOLD;
				end
			endcase
		end
	end

	always_comb begin
		case (lane_q)
			2'd0: begin
				a_sel = 18'(slot_q.src.x);
				b_sel = 18'(slot_q.dst.x);
			end
			2'd1: begin
				a_sel = 18'(slot_q.src.y);
				b_sel = 18'(slot_q.dst.y);
			end
			2'd2: begin
				a_sel = 18'($signed({1'b0, slot_q.src.w}));
				b_sel = 18'($signed({1'b0, slot_q.dst.w}));
			end
			default: begin
				a_sel = 18'($signed({1'b0, slot_q.src.h}));
				b_sel = 18'($signed({1'b0, slot_q.dst.h}));
			end
		endcase
	end

	assign qt = prod_q[27] ? ((prod_q + 28'sd255) >>> 8) : (prod_q >>> 8);

	always_comb begin
		ox = lerp_q[0];
		oy = lerp_q[1];
		ow = lerp_q[2];
		oh = lerp_q[3];
		alpha_v = 8'd255;
		if (slot_q.kind == KIND_SHADE || slot_q.kind == KIND_UNSHADE) begin
			ox = 18'(slot_q.src.x);
			oy = 18'(slot_q.src.y);
			ow = 18'($signed({1'b0, slot_q.src.w}));
		end else if (slot_q.kind == KIND_HOLD) begin
			ox = 18'(req_q.win_x);
			oy = 18'(req_q.win_y);
			ow = 18'($signed({1'b0, req_q.win_w}));
			oh = 18'($signed({1'b0, req_q.win_h}));
		end else if (slot_q.kind == KIND_CLOSE || slot_q.kind == KIND_MIN) begin
			alpha_v = (t_q == 9'd0) ? 8'd255 : 8'(T_FULL - t_q);
		end else begin
			alpha_v = (t_q == T_FULL) ? 8'd255 : t_q[7:0];
		end
		if (ow < 18'sd1) begin
			ow = 18'sd1;
		end
		if (oh < 18'sd1) begin
			oh = 18'sd1;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		active_d = active_q;
		done_d = done_q;
		found_d = found_q;
		sel_d = sel_q;
		fin_d = fin_q;
		lane_d = lane_q;
		emit = 1'b0;
		emit_item = '0;
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = tick_slot;
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					idx_d = '0;
					found_d = 1'b0;
					fin_d = 1'b0;
					done_d = '0;
					lane_d = '0;
					if (req.func <= FUNC_APPLY) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (fin_q) begin
					if (done_q[idx_q]) begin
						emit = 1'b1;
						emit_item.result_kind = RES_FINISHED;
						emit_item.event_window = rd.window;
						emit_item.finished_kind = rd.kind;
					end
					if (!done_q[idx_q] || out_free) begin
						idx_d = is_last ? '0 : idx_q + IW'(1);
						state_d = is_last ? ST_TAIL : ST_READ;
					end
				end else begin
					case (req_q.func)
						FUNC_START, FUNC_START_MIN: begin
							if (match) begin
								found_d = 1'b1;
								sel_d = idx_q;
								state_d = ST_START;
							end else if (is_last) begin
								state_d = ST_START;
							end else begin
								idx_d = idx_q + IW'(1);
								state_d = ST_READ;
							end
						end
						FUNC_TICK: begin
							if (active_q[idx_q]) begin
								ram_we = 1'b1;
								if (frame1 >= rd.dur) begin
									active_d[idx_q] = 1'b0;
									done_d[idx_q] = 1'b1;
								end
							end
							if (is_last) begin
								fin_d = 1'b1;
								idx_d = '0;
							end else begin
								idx_d = idx_q + IW'(1);
							end
							state_d = ST_READ;
						end
						FUNC_CANCEL: begin
							if (match) begin
								active_d[idx_q] = 1'b0;
							end
							idx_d = is_last ? '0 : idx_q + IW'(1);
							state_d = is_last ? ST_TAIL : ST_READ;
						end
						default: begin
							if (match) begin
								div_req.start = 1'b1;
								div_req.frame = rd.frame;
								div_req.dur = rd.dur;
								found_d = 1'b1;
								state_d = ST_DIV;
							end else if (is_last) begin
								state_d = ST_TAIL;
							end else begin
								idx_d = idx_q + IW'(1);
								state_d = ST_READ;
							end
						end
					endcase
				end
			end
			ST_START: begin
				emit = 1'b1;
				emit_item.event_window = req_q.window_id;
				if (found_q || free_any) begin
					emit_item.result_kind = RES_STARTED;
					if (out_free) begin
						ram_we = 1'b1;
						ram_waddr = start_idx;
						ram_wdata = new_slot;
						active_d[start_idx] = 1'b1;
					end
				end else begin
					emit_item.result_kind = RES_NO_SLOT;
				end
				emit_item.last_item = 1'b1;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_TAIL: begin
				emit = 1'b1;
				emit_item.last_item = 1'b1;
				case (req_q.func)
					FUNC_TICK: begin
						emit_item.result_kind = RES_TICK_DONE;
					end
					FUNC_CANCEL: begin
						emit_item.result_kind = RES_CANCELLED;
						emit_item.event_window = req_q.window_id;
					end
					default: begin
						emit_item.result_kind = RES_GEOMETRY;
						emit_item.event_window = req_q.window_id;
						emit_item.pos_x = req_q.win_x;
						emit_item.pos_y = req_q.win_y;
						emit_item.size_w = req_q.win_w;
						emit_item.size_h = req_q.win_h;
						emit_item.alpha = 8'd255;
					end
				endcase
				if (out_free) begin
					done_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				lane_d = lane_q + 2'd1;
				state_d = (lane_q == 2'd3) ? ST_GEOM : ST_MUL;
			end
			ST_GEOM: begin
				emit = 1'b1;
				emit_item.result_kind = RES_GEOMETRY;
				emit_item.event_window = req_q.window_id;
				emit_item.pos_x = ox[15:0];
				emit_item.pos_y = oy[15:0];
				emit_item.size_w = ow[14:0];
				emit_item.size_h = oh[14:0];
				emit_item.alpha = alpha_v;
				emit_item.last_item = 1'b1;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		emit_item.any_active = |active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			active_q <= '0;
			done_q <= '0;
			found_q <= 1'b0;
			sel_q <= '0;
			fin_q <= 1'b0;
			lane_q <= '0;
			out_valid_q <= 1'b0;
			open_q <= FRAMES_RESET;
			close_q <= FRAMES_RESET;
			restore_q <= FRAMES_RESET;
			shade_q <= FRAMES_RESET;
			unshade_q <= FRAMES_RESET;
			minimize_q <= FRAMES_RESET;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			active_q <= active_d;
			done_q <= done_d;
			found_q <= found_d;
			sel_q <= sel_d;
			fin_q <= fin_d;
			lane_q <= lane_d;
			if (emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_OPEN: open_q <= cfg.data;
					CFG_CLOSE: close_q <= cfg.data;
					CFG_RESTORE: restore_q <= cfg.data;
					CFG_SHADE: shade_q <= cfg.data;
					CFG_UNSHADE: unshade_q <= cfg.data;
					CFG_MINIMIZE: minimize_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= '{req.func, req.window_id, req.anim_kind, req.win_x, req.win_y,
				req.win_w, req.win_h, req.saved_height, req.target_x, req.target_y,
				req.target_w, req.target_h};
		end
		if (div_req.start) begin
			slot_q <= rd;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			t_q <= (slot_q.dur == '0 || slot_q.frame >= slot_q.dur) ? T_FULL
				: {1'b0, curve(slot_q.kind, div_rsp.quot)};
		end
		if (state_q == ST_MUL) begin
			prod_q <= (b_sel - a_sel) * $signed({1'b0, t_q});
		end
		if (state_q == ST_ACC) begin
			lerp_q[lane_q] <= a_sel + qt[17:0];
		end
		if (emit && out_free) begin
			out_q <= emit_item;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.result_kind = out_q.result_kind;
	assign rsp.event_window = out_q.event_window;
	assign rsp.finished_kind = out_q.finished_kind;
	assign rsp.pos_x = out_q.pos_x;
	assign rsp.pos_y = out_q.pos_y;
	assign rsp.size_w = out_q.size_w;
	assign rsp.size_h = out_q.size_h;
	assign rsp.alpha = out_q.alpha;
	assign rsp.any_active = out_q.any_active;
	assign rsp.last_item = out_q.last_item;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST) else $error("slot index out of range");
	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q != ST_IDLE) else $error("slot write while idle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> done_q == '0) else $error("finish mask left set");
	a_known_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req.func <= FUNC_APPLY |=> state_q != ST_IDLE)
		else $error("request dropped");
endmodule

@@ sim/wawe_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts and compares every result of the window animation easing engine.
module wawe_checker import wawe_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	wawe_req_if  req,
	wawe_rsp_if  rsp,
	wawe_cfg_if  cfg,
	output int   errors,
	output int   pending,
	output int   checked
);

	typedef struct {
		int x;
		int y;
		int w;
		int h;
	} box_t;

	bit          live [SLOTS];
	logic [15:0] owner [SLOTS];
	logic [2:0]  anim [SLOTS];
	int          frame_no [SLOTS];
	int          span [SLOTS];
	box_t        from_box [SLOTS];
	box_t        to_box [SLOTS];
	int          frames_cfg [6];
	rsp_t        expected_q [$];

	assign pending = expected_q.size();

	function automatic int clip(input int v, input int lo, input int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic box_t make_box(input int x, input int y, input int w, input int h);
		box_t b;
		b.x = clip(x, -32768, 32767);
		b.y = clip(y, -32768, 32767);
		b.w = clip(w, 0, 32767);
		b.h = clip(h, 0, 32767);
		return b;
	endfunction

	function automatic int ease(input logic [2:0] k, input int f, input int d);
		int idx;
		if (d == 0 || f >= d) begin
			return 256;
		end
		idx = ((f * 63) / d) & 63;
		if (k == KIND_MIN || k == KIND_SHADE) begin
			return CURVE_IN[idx];
		end else if (k == KIND_UNSHADE) begin
			return CURVE_BOUNCE[idx];
		end
		return CURVE_OUT[idx];
	endfunction

	function automatic int blend(input int a, input int b, input int t);
		return a + ((b - a) * t) / 256;
	endfunction

	task automatic predict_results(input req_t q);
		rsp_t outs [SLOTS + 1];
		int   n;
		int   s;
		int   x, y, w, h, sh, t;
		int   ox, oy, ow, oh, alpha;
		bit   act;
		n = 0;
		s = -1;
		x = $signed(q.win_x);
		y = $signed(q.win_y);
		w = q.win_w;
		h = q.win_h;
		sh = q.saved_height;
		foreach (outs[i]) outs[i] = '0;
		case (q.func)
			FUNC_START, FUNC_START_MIN: begin
				for (int i = 0; i < SLOTS; i++)
					if (s < 0 && live[i] && owner[i] == q.window_id) s = i;
				for (int i = 0; i < SLOTS; i++)
					if (s < 0 && !live[i]) s = i;
				outs[0].event_window = q.window_id;
				if (s < 0) begin
					outs[0].result_kind = RES_NO_SLOT;
				end else begin
					outs[0].result_kind = RES_STARTED;
					live[s] = 1'b1;
					owner[s] = q.window_id;
					frame_no[s] = 0;
					from_box[s] = make_box(x, y, w, h);
					to_box[s] = make_box(x, y, w, h);
					if (q.func == FUNC_START_MIN) begin
						anim[s] = KIND_MIN;
						span[s] = frames_cfg[CFG_MINIMIZE];
						to_box[s] = make_box($signed(q.target_x), $signed(q.target_y),
							q.target_w, q.target_h);
					end else begin
						anim[s] = q.anim_kind;
						case (q.anim_kind)
							KIND_OPEN: begin
								span[s] = frames_cfg[CFG_OPEN];
								from_box[s] = make_box(x + w / 4, y + h / 4, w / 2, h / 2);
							end
							KIND_CLOSE: begin
								span[s] = frames_cfg[CFG_CLOSE];
								to_box[s] = make_box(x + w / 4, y + h / 4, w / 2, h / 2);
							end
							KIND_RESTORE: begin
								span[s] = frames_cfg[CFG_RESTORE];
								from_box[s] = make_box(x + w / 2, y + h / 2, 0, 0);
							end
							KIND_SHADE: begin
								span[s] = frames_cfg[CFG_SHADE];
								to_box[s].h = 0;
							end
							KIND_UNSHADE: begin
								span[s] = frames_cfg[CFG_UNSHADE];
								from_box[s].h = 0;
								to_box[s].h = sh > 0 ? sh : h;
							end
							default: begin
								anim[s] = KIND_HOLD;
								span[s] = frames_cfg[CFG_OPEN];
							end
						endcase
					end
				end
				n = 1;
			end
			FUNC_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (live[i]) begin
						frame_no[i] = (frame_no[i] + 1) & 1023;
						if (frame_no[i] >= span[i]) begin
							live[i] = 1'b0;
							outs[n].result_kind = RES_FINISHED;
							outs[n].event_window = owner[i];
							outs[n].finished_kind = anim[i];
							n++;
						end
					end
				end
				outs[n].result_kind = RES_TICK_DONE;
				n++;
			end
			FUNC_CANCEL: begin
				for (int i = 0; i < SLOTS; i++)
					if (live[i] && owner[i] == q.window_id) live[i] = 1'b0;
				outs[0].result_kind = RES_CANCELLED;
				outs[0].event_window = q.window_id;
				n = 1;
			end
			FUNC_APPLY: begin
				ox = x;
				oy = y;
				ow = w;
				oh = h;
				alpha = 255;
				for (int i = 0; i < SLOTS; i++) begin
					if (s < 0 && live[i] && owner[i] == q.window_id) begin
						s = i;
						t = ease(anim[i], frame_no[i], span[i]);
						if (anim[i] == KIND_SHADE || anim[i] == KIND_UNSHADE) begin
							ox = from_box[i].x;
							oy = from_box[i].y;
							ow = from_box[i].w;
							oh = blend(from_box[i].h, to_box[i].h, t);
						end else if (anim[i] != KIND_HOLD) begin
							ox = blend(from_box[i].x, to_box[i].x, t);
							oy = blend(from_box[i].y, to_box[i].y, t);
							ow = blend(from_box[i].w, to_box[i].w, t);
							oh = blend(from_box[i].h, to_box[i].h, t);
							alpha = (anim[i] == KIND_CLOSE || anim[i] == KIND_MIN) ? 256 - t : t;
							if (alpha > 255) alpha = 255;
						end
						if (ow < 1) ow = 1;
						if (oh < 1) oh = 1;
					end
				end
				outs[0].result_kind = RES_GEOMETRY;
				outs[0].event_window = q.window_id;
				outs[0].pos_x = ox[15:0];
				outs[0].pos_y = oy[15:0];
				outs[0].size_w = ow[14:0];
				outs[0].size_h = oh[14:0];
				outs[0].alpha = alpha[7:0];
				n = 1;
			end
			default: n = 0;
		endcase
		act = 1'b0;
		foreach (live[i]) act |= live[i];
		for (int k = 0; k < n; k++) begin
			outs[k].any_active = act;
			outs[k].last_item = (k == n - 1);
			expected_q.push_back(outs[k]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		req_t q;
		rsp_t got;
		rsp_t want;
		if (!arst_n) begin
			foreach (live[i]) live[i] = 1'b0;
			foreach (frames_cfg[i]) frames_cfg[i] = FRAMES_RESET;
			expected_q.delete();
			errors = 0;
			checked = 0;
		end else begin
			if (cfg.valid && cfg.ready && cfg.index <= CFG_MINIMIZE)
				frames_cfg[cfg.index] = cfg.data;
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.result_kind, rsp.event_window, rsp.finished_kind, rsp.pos_x,
					rsp.pos_y, rsp.size_w, rsp.size_h, rsp.alpha, rsp.any_active,
					rsp.last_item};
				checked++;
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result at %0t: %p", $time, got);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch at %0t:\n  expected %p\n  actual   %p",
								$time, want, got);
					end
				end
			end
			if (req.valid && req.ready) begin
				q = '{req.func, req.window_id, req.anim_kind, req.win_x, req.win_y,
					req.win_w, req.win_h, req.saved_height, req.target_x, req.target_y,
					req.target_w, req.target_h};
				predict_results(q);
			end
		end
	end

endmodule

@@ sim/tb_window_animation_easing_engine_core.sv @@
`timescale 1ns / 100ps
// Testbench top: stimulus, handshake idling and verdict for the easing engine core.
module tb_window_animation_easing_engine_core;
	import wawe_pkg::*;

	localparam int SLOTS = 8;
	localparam int SETTLE = 80;
	localparam int LIMIT = 600000;
	localparam int PHASE_ITEMS = 95;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm;
	bit   squeeze;
	bit   squeeze_seen;
	int   hold_left;
	int   cycles;
	int   errors;
	int   pending;
	int   checked;
	int   sent;
	logic [15:0] ids [10] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7,
		16'd8, 16'hFFFF};
	int plan [4][6] = '{
		'{1, 1, 1, 1, 1, 1},
		'{3, 5, 2, 4, 6, 7},
		'{0, 1023, 3, 5, 8, 2},
		'{1023, 2, 1023, 1, 1023, 4}};

	wawe_req_if req_if();
	wawe_rsp_if rsp_if();
	wawe_cfg_if cfg_if();

	window_animation_easing_engine_core #(.SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n), .req(req_if), .rsp(rsp_if), .cfg(cfg_if));

	wawe_checker #(.SLOTS(SLOTS)) u_checker (
		.clk(clk), .arst_n(arst_n), .req(req_if), .rsp(rsp_if), .cfg(cfg_if),
		.errors(errors), .pending(pending), .checked(checked));

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[window_animation_easing_engine_core] ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (squeeze && !squeeze_seen) begin
			squeeze_seen = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_if.ready = 1'b0;
		end else begin
			rsp_if.ready = calm || $urandom_range(99) >= 17;
		end
	end

	function automatic req_t make_req(input logic [2:0] f, input logic [15:0] wid,
		input logic [2:0] k, input int x, input int y, input int w, input int h,
		input int sh, input int tx, input int ty, input int tw, input int th);
		req_t q;
		q = '{f, wid, k, x[15:0], y[15:0], w[14:0], h[14:0], sh[14:0], tx[15:0],
			ty[15:0], tw[14:0], th[14:0]};
		return q;
	endfunction

	function automatic req_t random_req();
		req_t q;
		int   roll;
		q = '0;
		q.window_id = 16'($urandom);
		q.win_x = 16'($urandom);
		q.win_y = 16'($urandom);
		q.win_w = 15'($urandom);
		q.win_h = 15'($urandom);
		q.saved_height = 15'($urandom);
		q.target_x = 16'($urandom);
		q.target_y = 16'($urandom);
		q.target_w = 15'($urandom);
		q.target_h = 15'($urandom);
		if ($urandom_range(9) != 0) q.window_id = ids[$urandom_range(9)];
		if ($urandom_range(3) == 0) q.saved_height = '0;
		roll = $urandom_range(99);
		if (roll < 30) q.func = FUNC_START;
		else if (roll < 40) q.func = FUNC_START_MIN;
		else if (roll < 67) q.func = FUNC_TICK;
		else if (roll < 75) q.func = FUNC_CANCEL;
		else if (roll < 98) q.func = FUNC_APPLY;
		else q.func = 3'($urandom_range(7, 5));
		q.anim_kind = $urandom_range(9) == 0 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
		return q;
	endfunction

	task automatic send(input req_t q);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 17) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		{req_if.func, req_if.window_id, req_if.anim_kind, req_if.win_x, req_if.win_y,
			req_if.win_w, req_if.win_h, req_if.saved_height, req_if.target_x,
			req_if.target_y, req_if.target_w, req_if.target_h} = q;
		req_if.valid = 1'b1;
		do @(posedge clk); while (!req_if.ready);
		sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [9:0] value);
		@(negedge clk);
		cfg_if.index = idx;
		cfg_if.data = value;
		cfg_if.valid = 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	initial begin
		req_if.valid = 1'b0;
		{req_if.func, req_if.window_id, req_if.anim_kind, req_if.win_x, req_if.win_y,
			req_if.win_w, req_if.win_h, req_if.saved_height, req_if.target_x,
			req_if.target_y, req_if.target_w, req_if.target_h} = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(make_req(FUNC_START, 1, KIND_OPEN, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0));
		send(make_req(FUNC_APPLY, 1, 0, 5, 6, 7, 8, 0, 0, 0, 0, 0));
		send(make_req(FUNC_START, 2, KIND_CLOSE, -32768, -32768, 0, 0, 0, 0, 0, 0, 0));
		send(make_req(FUNC_START, 3, KIND_RESTORE, 100, -50, 301, 77, 0, 0, 0, 0, 0));
		send(make_req(FUNC_START, 4, KIND_SHADE, -7, 9, 640, 480, 0, 0, 0, 0, 0));
		send(make_req(FUNC_START, 5, KIND_UNSHADE, 12, 34, 200, 150, 0, 0, 0, 0, 0));
		send(make_req(FUNC_START, 6, KIND_UNSHADE, 12, 34, 200, 150, 1234, 0, 0, 0, 0));
		send(make_req(FUNC_START, 7, 3'd7, 1, 2, 3, 4, 0, 0, 0, 0, 0));
		send(make_req(FUNC_START_MIN, 8, 0, 300, 200, 800, 600, 0, -32768, 32767,
			32767, 0));
		send(make_req(FUNC_START, 9, KIND_OPEN, 1, 1, 1, 1, 0, 0, 0, 0, 0));
		send(make_req(FUNC_START, 1, KIND_OPEN, 10, 20, 400, 300, 0, 0, 0, 0, 0));
		send(make_req(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 1; i <= 8; i++)
			send(make_req(FUNC_APPLY, i[15:0], 0, -1, -1, 32767, 32767, 0, 0, 0, 0, 0));
		send(make_req(FUNC_APPLY, 16'hFFFF, 0, -32768, 32767, 0, 32767, 0, 0, 0, 0, 0));
		send(make_req(FUNC_CANCEL, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(make_req(3'd7, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(make_req(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(make_req(FUNC_CANCEL, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		settle();

		for (int p = 0; p < 4; p++) begin
			for (int r = 0; r < 6; r++) write_reg(r[2:0], plan[p][r][9:0]);
			write_reg(3'd6, 10'h3FF);
			write_reg(3'd7, 10'h155);
			calm = (p == 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 20) squeeze = 1'b1;
				send(random_req());
			end
			calm = 1'b0;
			settle();
		end

		$display("Sent %0d requests over five duration settings; checked %0d results.",
			sent, checked);
		$display("Covered starts of every kind, no-slot, ticks, cancels and applies.");
		if (errors == 0) begin
			$display("[window_animation_easing_engine_core] OK");
		end else begin
			$display("[window_animation_easing_engine_core] ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/wawe_pkg.sv
design/wawe_if.sv
design/wawe_ram.sv
design/wawe_div.sv
design/window_animation_easing_engine_core.sv
sim/wawe_checker.sv
sim/tb_window_animation_easing_engine_core.sv
